// ===== design/rau_pkg.sv =====
// Shared widths, types and codes for the rational arithmetic unit.
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int DEN_W         = OPERAND_WIDTH - 1;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int SUM_W         = PROD_W + 1;
  localparam int MAG_W         = PROD_W;
  localparam int SHIFT_W       = $clog2(MAG_W);
  localparam int RES_NUM_W     = 32;
  localparam int RES_DEN_W     = 30;
  localparam int OP_W          = 3;
  localparam int CMP_W         = 2;

  typedef logic signed [OPERAND_WIDTH-1:0] opnd_t;
  typedef logic        [DEN_W-1:0]         den_t;
  typedef logic signed [PROD_W-1:0]        prod_t;
  typedef logic signed [SUM_W-1:0]         sum_t;
  typedef logic        [MAG_W-1:0]         mag_t;
  typedef logic        [SHIFT_W-1:0]       shift_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  localparam logic [CMP_W-1:0] CMP_LESS    = 2'd0;
  localparam logic [CMP_W-1:0] CMP_EQUAL   = 2'd1;
  localparam logic [CMP_W-1:0] CMP_GREATER = 2'd2;

endpackage

// ===== design/rational_arithmetic_unit_top.sv =====
// Rational arithmetic unit: sequencer, shared multiplier, GCD and divider.
// Sequence: the multiply steps (S_MUL), then form (S_FORM) and check (S_CHECK); compare, zero,
//   error and unused-code cases give the result beat from the check. Reduced results go on
//   through the GCD loop (S_GCD) and the divider (S_DIV) before the result beat.
// Throughput: one item at a time; busy_o is high until the result beat (done_o, no stall).
// Reset (rst_ni low, asynchronous) returns the sequencer to idle, no beat pending.
module rational_arithmetic_unit_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [rau_pkg::OP_W-1:0]        operation_i,
  input  rau_pkg::opnd_t                  left_numerator_i,
  input  rau_pkg::den_t                   left_denominator_i,
  input  rau_pkg::opnd_t                  right_numerator_i,
  input  rau_pkg::den_t                   right_denominator_i,
  output logic                            done_o,
  output logic signed [rau_pkg::RES_NUM_W-1:0] result_numerator_o,
  output logic [rau_pkg::RES_DEN_W-1:0]   result_denominator_o,
  output logic                            divide_error_o,
  output logic [rau_pkg::CMP_W-1:0]       compare_result_o
);
  import rau_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_FORM  = 6'b000100,
    S_CHECK = 6'b001000,
    S_GCD   = 6'b010000,
    S_DIV   = 6'b100000
  } state_e;

  state_e state_q;
  logic [1:0] step_q;
  logic       accept;

  logic [OP_W-1:0] op_q;
  opnd_t ln_q, rn_q, ld_q, rd_q;
  opnd_t ma, mb;
  prod_t mprod, p0_q, p1_q, p2_q;
  sum_t  num_d, den_d, num_q, den_q;
  logic  num_neg, den_neg, neg_q;
  mag_t  mag_n, mag_d, mag_n_q, mag_d_q;
  logic  special;

  logic  gcd_start, gcd_done, div_start, div_done;
  mag_t  gcd_val, qn, qd;
  logic signed [MAG_W:0] signed_q;

  logic                    done_q, div_err_q;
  logic signed [RES_NUM_W-1:0] res_num_q;
  logic [RES_DEN_W-1:0]    res_den_q;
  logic [CMP_W-1:0]        cmp_q;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // Pick multiplier operands for each of the three product steps
  always_comb begin
    case (step_q)
      2'd0: begin
        ma = ln_q;
        mb = (op_q == OP_MUL) ? rn_q : rd_q;
      end
      2'd1: begin
        ma = ld_q;
        mb = rn_q;
      end
      default: begin
        ma = ld_q;
        mb = rd_q;
      end
    endcase
  end

  assign mprod = ma * mb;

  // Form raw numerator and denominator from the products
  always_comb begin
    den_d = sum_t'(p2_q);
    case (op_q) inside
      OP_ADD:          num_d = sum_t'(p0_q) + sum_t'(p1_q);
      OP_SUB, OP_CMP:  num_d = sum_t'(p0_q) - sum_t'(p1_q);
      OP_MUL:          num_d = sum_t'(p0_q);
      OP_DIV: begin
        num_d = sum_t'(p0_q);
        den_d = sum_t'(p1_q);
      end
      default:         num_d = '0;
    endcase
  end

  // Signs and magnitudes of the raw fraction
  assign num_neg = num_q[SUM_W-1];
  assign den_neg = den_q[SUM_W-1];
  assign mag_n   = MAG_W'(num_neg ? -num_q : num_q);
  assign mag_d   = MAG_W'(den_neg ? -den_q : den_q);
  assign special = (op_q == OP_CMP) || (op_q > OP_CMP) || (num_q == '0) ||
                   ((op_q == OP_DIV) && (rn_q == '0));

  assign gcd_start = (state_q == S_CHECK) && !special;
  assign div_start = (state_q == S_GCD) && gcd_done;

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (mag_n),
    .b_i     (mag_d),
    .done_o  (gcd_done),
    .gcd_o   (gcd_val)
  );

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .num_i      (mag_n_q),
    .den_i      (mag_d_q),
    .divisor_i  (gcd_val),
    .done_o     (div_done),
    .num_quot_o (qn),
    .den_quot_o (qd)
  );

  assign signed_q = neg_q ? -$signed({1'b0, qn}) : $signed({1'b0, qn});

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_MUL;
            step_q  <= '0;
          end
        end
        S_MUL: begin
          step_q <= step_q + 1'b1;
          if (step_q == 2'd2) begin
            state_q <= S_FORM;
          end
        end
        S_FORM: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (special) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Capture operands, products and results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= operation_i;
      ln_q <= left_numerator_i;
      rn_q <= right_numerator_i;
      ld_q <= (left_denominator_i == '0) ? opnd_t'(1) : opnd_t'({1'b0, left_denominator_i});
      rd_q <= (right_denominator_i == '0) ? opnd_t'(1) :
              opnd_t'({1'b0, right_denominator_i});
    end
    if (state_q == S_MUL) begin
      case (step_q)
        2'd0:    p0_q <= mprod;
        2'd1:    p1_q <= mprod;
        default: p2_q <= mprod;
      endcase
    end
    if (state_q == S_FORM) begin
      num_q <= num_d;
      den_q <= den_d;
    end
    if (state_q == S_CHECK) begin
      mag_n_q   <= mag_n;
      mag_d_q   <= mag_d;
      neg_q     <= num_neg ^ den_neg;
      res_num_q <= '0;
      res_den_q <= RES_DEN_W'(1);
      div_err_q <= 1'b0;
      cmp_q     <= CMP_LESS;
      if (op_q == OP_CMP) begin
        cmp_q <= num_neg ? CMP_LESS : ((num_q == '0) ? CMP_EQUAL : CMP_GREATER);
      end else if ((op_q == OP_DIV) && (rn_q == '0)) begin
        res_den_q <= '0;
        div_err_q <= 1'b1;
      end
    end
    if ((state_q == S_DIV) && div_done) begin
      res_num_q <= RES_NUM_W'(signed_q);
      res_den_q <= RES_DEN_W'(qd);
    end
  end

  assign done_o               = done_q;
  assign result_numerator_o   = res_num_q;
  assign result_denominator_o = res_den_q;
  assign divide_error_o       = div_err_q;
  assign compare_result_o     = cmp_q;

endmodule

// ===== design/rau_gcd.sv =====
// Binary GCD engine: one compare, subtract or shift step per cycle.
module rau_gcd (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rau_pkg::mag_t a_i,
  input  rau_pkg::mag_t b_i,
  output logic          done_o,
  output rau_pkg::mag_t gcd_o
);
  import rau_pkg::*;

  logic   busy_q, done_q;
  mag_t   a_q, b_q, g_q;
  shift_t k_q;
  logic [MAG_W:0] diff_ab;
  mag_t   diff_ba;
  logic   a_lt_b, equal;

  // Shared subtractor pair and compare
  assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
  assign diff_ba = b_q - a_q;
  assign a_lt_b  = diff_ab[MAG_W];
  assign equal   = (a_q == b_q);

  // Track busy and pulse done when both values meet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && equal) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Step the operands: drop common twos, drop single twos, subtract odd pairs
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (equal) begin
        g_q <= a_q << k_q;
      end else if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (!a_lt_b) begin
        a_q <= diff_ab[MAG_W-1:0] >> 1;
      end else begin
        b_q <= diff_ba >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign gcd_o  = g_q;

endmodule

// ===== design/rau_div.sv =====
// Two-lane restoring divider: numerator and denominator over a common divisor.
module rau_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rau_pkg::mag_t num_i,
  input  rau_pkg::mag_t den_i,
  input  rau_pkg::mag_t divisor_i,
  output logic          done_o,
  output rau_pkg::mag_t num_quot_o,
  output rau_pkg::mag_t den_quot_o
);
  import rau_pkg::*;

  logic   busy_q, done_q;
  shift_t cnt_q;
  mag_t   dv_q, rn_q, rd_q, qn_q, qd_q;
  logic [MAG_W:0] trial_n, trial_d, sub_n, sub_d;

  // One trial subtract per lane per bit
  assign trial_n = {rn_q, qn_q[MAG_W-1]};
  assign trial_d = {rd_q, qd_q[MAG_W-1]};
  assign sub_n   = trial_n - {1'b0, dv_q};
  assign sub_d   = trial_d - {1'b0, dv_q};

  // Count quotient bits and pulse done after the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == shift_t'(MAG_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift dividend out, quotient bit in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q <= divisor_i;
      rn_q <= '0;
      rd_q <= '0;
      qn_q <= num_i;
      qd_q <= den_i;
    end else if (busy_q) begin
      if (!sub_n[MAG_W]) begin
        rn_q <= sub_n[MAG_W-1:0];
        qn_q <= {qn_q[MAG_W-2:0], 1'b1};
      end else begin
        rn_q <= trial_n[MAG_W-1:0];
        qn_q <= {qn_q[MAG_W-2:0], 1'b0};
      end
      if (!sub_d[MAG_W]) begin
        rd_q <= sub_d[MAG_W-1:0];
        qd_q <= {qd_q[MAG_W-2:0], 1'b1};
      end else begin
        rd_q <= trial_d[MAG_W-1:0];
        qd_q <= {qd_q[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign num_quot_o = qn_q;
  assign den_quot_o = qd_q;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the rational arithmetic unit: directed and random fraction beats.
module tb_top;
  import rau_pkg::*;

  localparam int STALL_LIMIT = 1000;  // cycles with no beat in either direction
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] num;
    logic [RES_DEN_W-1:0]        den;
    logic                        div_err;
    logic [CMP_W-1:0]            cmp;
  } fraction_result_t;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic [OP_W-1:0]             operation_i = '0;
  opnd_t                       left_numerator_i = '0;
  den_t                        left_denominator_i = '0;
  opnd_t                       right_numerator_i = '0;
  den_t                        right_denominator_i = '0;
  logic                        done_o;
  logic signed [RES_NUM_W-1:0] result_numerator_o;
  logic [RES_DEN_W-1:0]        result_denominator_o;
  logic                        divide_error_o;
  logic [CMP_W-1:0]            compare_result_o;

  fraction_result_t            pending_fractions[$];
  int                          mismatches = 0;
  int                          quiet_cycles = 0;
  int                          sender_idle_pct = 0;

  rational_arithmetic_unit_top u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .operation_i         (operation_i),
    .left_numerator_i    (left_numerator_i),
    .left_denominator_i  (left_denominator_i),
    .right_numerator_i   (right_numerator_i),
    .right_denominator_i (right_denominator_i),
    .done_o              (done_o),
    .result_numerator_o  (result_numerator_o),
    .result_denominator_o(result_denominator_o),
    .divide_error_o      (divide_error_o),
    .compare_result_o    (compare_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Divide num/den by the GCD of the magnitudes; the sign goes to the numerator.
  function automatic fraction_result_t reduce_fraction(input longint num, input longint den);
    fraction_result_t       r;
    logic                   neg;
    longint unsigned        mag_n;
    longint unsigned        mag_d;
    longint unsigned        a;
    longint unsigned        b;
    longint unsigned        t;
    logic [63:0]            signed_n;
    r = '{num: '0, den: RES_DEN_W'(1), div_err: 1'b0, cmp: CMP_LESS};
    if (num == 0) return r;
    neg   = (num < 0) != (den < 0);
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    a = mag_n;
    b = mag_d;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    if (a == 0) a = 1;
    mag_n = mag_n / a;
    mag_d = mag_d / a;
    signed_n = neg ? (64'd0 - mag_n) : mag_n;
    r.num = signed_n[RES_NUM_W-1:0];
    r.den = mag_d[RES_DEN_W-1:0];
    return r;
  endfunction

  // Work out the result beat for one operation on two fractions.
  function automatic fraction_result_t predict_fraction(input logic [OP_W-1:0] op,
                                                        input opnd_t ln_f, input den_t ld_f,
                                                        input opnd_t rn_f, input den_t rd_f);
    fraction_result_t r;
    longint           ln;
    longint           ld;
    longint           rn;
    longint           rd;
    longint           diff;
    ln = ln_f;
    rn = rn_f;
    ld = (ld_f == 0) ? 1 : ld_f;
    rd = (rd_f == 0) ? 1 : rd_f;
    r = '{num: '0, den: RES_DEN_W'(1), div_err: 1'b0, cmp: CMP_LESS};
    case (op)
      OP_ADD: r = reduce_fraction(ln * rd + ld * rn, ld * rd);
      OP_SUB: r = reduce_fraction(ln * rd - ld * rn, ld * rd);
      OP_MUL: r = reduce_fraction(ln * rn, ld * rd);
      OP_DIV: begin
        if (rn == 0) begin
          r.den     = '0;
          r.div_err = 1'b1;
        end else begin
          r = reduce_fraction(ln * rd, ld * rn);
        end
      end
      OP_CMP: begin
        diff  = ln * rd - ld * rn;
        r.cmp = (diff < 0) ? CMP_LESS : ((diff == 0) ? CMP_EQUAL : CMP_GREATER);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one item, with an optional random gap first; start stays high afterwards.
  task automatic send_item(input logic [OP_W-1:0] op, input opnd_t ln_f, input den_t ld_f,
                           input opnd_t rn_f, input den_t rd_f);
    int gap;
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 8);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i             <= 1'b1;
    operation_i         <= op;
    left_numerator_i    <= ln_f;
    left_denominator_i  <= ld_f;
    right_numerator_i   <= rn_f;
    right_denominator_i <= rd_f;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_fractions.push_back(predict_fraction(op, ln_f, ld_f, rn_f, rd_f));
  endtask

  // Drop start and hold off until every expected beat has come back.
  task automatic wait_until_drained();
    start_i <= 1'b0;
    while (pending_fractions.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [OP_W-1:0] rand_op();
    if ($urandom_range(0, 99) < 4) return OP_W'($urandom_range(5, 7));
    return OP_W'($urandom_range(OP_ADD, OP_CMP));
  endfunction

  function automatic opnd_t rand_numerator();
    logic [31:0] raw;
    int          v;
    raw = $urandom;
    case ($urandom_range(0, 3))
      0, 1: return raw[OPERAND_WIDTH-1:0];
      2: begin
        v = $signed($urandom_range(0, 100)) - 50;
        return v[OPERAND_WIDTH-1:0];
      end
      default: begin
        case ($urandom_range(0, 5))
          0: v = -32768;
          1: v = -32767;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          default: v = 32767;
        endcase
        return v[OPERAND_WIDTH-1:0];
      end
    endcase
  endfunction

  function automatic den_t rand_denominator();
    case ($urandom_range(0, 19))
      0: return '0;  // treated as one by the block
      1, 2, 3: return '1;
      4, 5, 6, 7, 8, 9: return DEN_W'($urandom_range(1, 60));
      default: return DEN_W'($urandom_range(1, 32767));
    endcase
  endfunction

  task automatic test_operand_extremes();
    send_item(OP_ADD, -16'sd32768, 15'd1, -16'sd32768, 15'd1);
    send_item(OP_SUB, 16'sd32767, 15'd1, -16'sd32768, 15'd1);
    send_item(OP_MUL, -16'sd32768, 15'd1, -16'sd32768, 15'd1);
    send_item(OP_MUL, -16'sd32768, 15'd32767, 16'sd32767, 15'd32766);
    send_item(OP_DIV, -16'sd32768, 15'd32767, 16'sd1, 15'd32767);
    send_item(OP_DIV, 16'sd32767, 15'd1, -16'sd32768, 15'd32767);
    send_item(OP_ADD, 16'sd32767, 15'd32767, 16'sd32767, 15'd32766);
    send_item(OP_CMP, -16'sd32768, 15'd1, 16'sd32767, 15'd1);
    send_item(OP_CMP, 16'sd32767, 15'd1, -16'sd32768, 15'd1);
  endtask

  task automatic test_special_cases();
    // divide by a zero fraction
    send_item(OP_DIV, 16'sd5, 15'd3, 16'sd0, 15'd7);
    send_item(OP_DIV, -16'sd32768, 15'd1, 16'sd0, 15'd32767);
    // negative divisor moves the sign to the numerator
    send_item(OP_DIV, 16'sd3, 15'd4, -16'sd3, 15'd8);
    // zero results collapse to 0/1, and 6/4 - 2/4 reduces to 1/1
    send_item(OP_ADD, 16'sd1, 15'd2, -16'sd1, 15'd2);
    send_item(OP_MUL, 16'sd0, 15'd5, 16'sd7, 15'd3);
    send_item(OP_SUB, 16'sd6, 15'd4, 16'sd2, 15'd4);
    // zero denominator fields count as one; then an equal compare
    send_item(OP_ADD, 16'sd3, 15'd0, 16'sd1, 15'd0);
    send_item(OP_CMP, 16'sd2, 15'd0, 16'sd4, 15'd2);
    send_item(OP_CMP, 16'sd1, 15'd3, 16'sd2, 15'd6);
    // unused operation codes
    send_item(3'd5, 16'sd9, 15'd2, 16'sd4, 15'd3);
    send_item(3'd6, -16'sd9, 15'd2, 16'sd4, 15'd3);
    send_item(3'd7, 16'sd0, 15'd0, 16'sd0, 15'd0);
  endtask

  // Compare fractions built from one ratio scaled two ways, so most come out equal.
  task automatic test_compare_equal(input int n_items);
    int a;
    int b;
    int k;
    int m;
    int ln;
    int ld;
    int rn;
    int rd;
    for (int i = 0; i < n_items; i++) begin
      a  = $signed($urandom_range(0, 400)) - 200;
      b  = $urandom_range(1, 150);
      k  = $urandom_range(1, 100);
      m  = $urandom_range(1, 100);
      ln = a * k;
      ld = b * k;
      rn = a * m + (($urandom_range(0, 4) == 0) ? 1 : 0);
      rd = b * m;
      send_item(OP_CMP, ln[OPERAND_WIDTH-1:0], ld[DEN_W-1:0], rn[OPERAND_WIDTH-1:0],
                rd[DEN_W-1:0]);
    end
  endtask

  task automatic test_random_mix(input int n_items, input int idle_pct);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < n_items; i++) begin
      send_item(rand_op(), rand_numerator(), rand_denominator(), rand_numerator(),
                rand_denominator());
      if (i == n_items / 2) wait_until_drained();
    end
  endtask

  task automatic check_field(input string field, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, field, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Match each result beat against the oldest expectation; count quiet cycles.
  always @(posedge clk_i) begin
    fraction_result_t exp_r;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_fractions.size() == 0) begin
        $display("%0t: unexpected result beat: actual %0d/%0d err %0b cmp %0d", $time,
                 result_numerator_o, result_denominator_o, divide_error_o, compare_result_o);
        mismatches++;
      end else begin
        exp_r = pending_fractions.pop_front();
        check_field("result_numerator", exp_r.num, result_numerator_o);
        check_field("result_denominator", 32'(exp_r.den), 32'(result_denominator_o));
        check_field("divide_error", 32'(exp_r.div_err), 32'(divide_error_o));
        check_field("compare_result", 32'(exp_r.cmp), 32'(compare_result_o));
      end
    end
    if ((start_i && busy_o === 1'b0) || done_o === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // End the run if beats stop moving.
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_operand_extremes();
    test_special_cases();
    test_random_mix(470, 0);
    test_random_mix(470, 76);
    test_compare_equal(40);
    test_random_mix(470, 0);
    test_random_mix(470, 28);

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_fractions.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_fractions.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== rational_arithmetic_unit_top.f =====
design/rau_pkg.sv
design/rau_gcd.sv
design/rau_div.sv
design/rational_arithmetic_unit_top.sv
sim/tb_top.sv
